// ===== rtl/core/tppg_pkg.sv =====
package tppg_pkg;

    localparam int TIME_BITS   = 32;
    localparam int PERIOD_BITS = 24;
    localparam int COUNT_BITS  = 16;
    localparam int AMP_BITS    = 16;

    // product of a period and a count
    localparam int PROD_BITS = PERIOD_BITS + COUNT_BITS;
    // room for base + width + second span and for the elapsed time
    localparam int CMP_BITS = (TIME_BITS + 1 > PROD_BITS + 2) ? TIME_BITS + 1 : PROD_BITS + 2;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_W0       = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;
    localparam int CFG_BITS     = (CFG_W0 > AMP_BITS) ? CFG_W0 : AMP_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_TIME    = 3'd0,
        CFG_PERIOD_FIRST  = 3'd1,
        CFG_COUNT_FIRST   = 3'd2,
        CFG_PERIOD_SECOND = 3'd3,
        CFG_COUNT_SECOND  = 3'd4,
        CFG_PULSE_WIDTH   = 3'd5,
        CFG_AMP_FIRST     = 3'd6,
        CFG_AMP_SECOND    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // side results of the remainder pipeline
    typedef struct packed {
        logic   pzero;
        logic   self_le;
        t_phase phase;
    } t_mod_res;

endpackage

// ===== rtl/core/tppg_in_if.sv =====
interface tppg_in_if;
    import tppg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] time_stamp;

    modport source (output valid, output time_stamp, input ready);
    modport sink (input valid, input time_stamp, output ready);

endinterface

// ===== rtl/core/tppg_out_if.sv =====
interface tppg_out_if;
    import tppg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [AMP_BITS-1:0] stim_amplitude;
    logic                       pulse_on;
    logic [1:0]                 train_phase;

    modport source (output valid, output stim_amplitude, output pulse_on,
                    output train_phase, input ready);
    modport sink (input valid, input stim_amplitude, input pulse_on,
                  input train_phase, output ready);

endinterface

// ===== rtl/core/tppg_mod_pipe.sv =====
module tppg_mod_pipe (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [tppg_pkg::TIME_BITS-1:0]   i_dividend,
    input  logic [tppg_pkg::PERIOD_BITS-1:0] i_divisor,
    input  logic [tppg_pkg::PERIOD_BITS-1:0] i_limit,
    input  tppg_pkg::t_phase                 i_phase,
    output logic                             o_valid,
    output logic [tppg_pkg::PERIOD_BITS-1:0] o_rem,
    output tppg_pkg::t_mod_res               o_res
);
    import tppg_pkg::*;

    localparam int NS = TIME_BITS;

    logic [NS-1:0]          r_v;
    logic [PERIOD_BITS-1:0] r_rem [NS];
    logic [TIME_BITS-1:0]   r_dvd [NS];
    logic [PERIOD_BITS-1:0] r_dvs [NS];
    t_mod_res               r_res [NS];

    // one restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [PERIOD_BITS-1:0] f_step(
        input logic [PERIOD_BITS-1:0] rem,
        input logic                   b,
        input logic [PERIOD_BITS-1:0] dvs
    );
        logic [PERIOD_BITS:0] trial;
        trial = {rem, b};
        if (trial >= {1'b0, dvs}) begin
            f_step = PERIOD_BITS'(trial - {1'b0, dvs});
        end else begin
            f_step = trial[PERIOD_BITS-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= f_step('0, i_dividend[TIME_BITS-1], i_divisor);
            r_dvd[0] <= i_dividend << 1;
            r_dvs[0] <= i_divisor;
            r_res[0] <= '{pzero:   (i_divisor == '0),
                          self_le: (CMP_BITS'(i_dividend) <= CMP_BITS'(i_limit)),
                          phase:   i_phase};
            for (int k = 1; k < NS; k++) begin
                r_rem[k] <= f_step(r_rem[k-1], r_dvd[k-1][TIME_BITS-1], r_dvs[k-1]);
                r_dvd[k] <= r_dvd[k-1] << 1;
                r_dvs[k] <= r_dvs[k-1];
                r_res[k] <= r_res[k-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_rem   = r_rem[NS-1];
    assign o_res   = r_res[NS-1];

endmodule

// ===== rtl/core/two_phase_pulse_train_generator.sv =====
// Two-phase (S1-S2) pulse train generator. Each input transfer carries an
// absolute time stamp in ticks; each output transfer gives the stimulus
// amplitude, a pulse-on flag and the train phase at that time. Before
// start_time the phase is 0 and the output is zero. The first train spans
// period_first*(count_first-1)+pulse_width ticks past start (a zero count
// counts as one); the second train follows for period_second*count_second
// more ticks, timed from the start of the last first-train pulse. A pulse is
// on while the time mod its period is at most pulse_width; a zero period
// uses the time itself. One time stamp is taken every cycle while input ready
// is high; each result passes through three front stages for the span
// products, span sums and phase select, one remainder stage per time bit in
// the bit-serial restoring pipeline, and one result stage. A two-entry
// output (result register plus skid) keeps input ready registered; a stall
// freezes the whole pipeline. The user must write configuration through a
// plain write port only while no transfer is in flight; the block itself
// does not enforce this.
module two_phase_pulse_train_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tppg_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [tppg_pkg::CFG_BITS-1:0]     i_cfg_data,
    tppg_in_if.sink                           i_in,
    tppg_out_if.source                        o_out
);
    import tppg_pkg::*;

    // configuration registers
    logic [TIME_BITS-1:0]       r_start;
    logic [PERIOD_BITS-1:0]     r_pf;
    logic [COUNT_BITS-1:0]      r_cf;
    logic [PERIOD_BITS-1:0]     r_ps;
    logic [COUNT_BITS-1:0]      r_cs;
    logic [PERIOD_BITS-1:0]     r_pw;
    logic signed [AMP_BITS-1:0] r_amp1;
    logic signed [AMP_BITS-1:0] r_amp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_pf    <= PERIOD_BITS'(1000);
            r_cf    <= COUNT_BITS'(1);
            r_ps    <= PERIOD_BITS'(1000);
            r_cs    <= '0;
            r_pw    <= PERIOD_BITS'(1);
            r_amp1  <= '0;
            r_amp2  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_TIME:    r_start <= i_cfg_data[TIME_BITS-1:0];
                CFG_PERIOD_FIRST:  r_pf    <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_COUNT_FIRST:   r_cf    <= i_cfg_data[COUNT_BITS-1:0];
                CFG_PERIOD_SECOND: r_ps    <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_COUNT_SECOND:  r_cs    <= i_cfg_data[COUNT_BITS-1:0];
                CFG_PULSE_WIDTH:   r_pw    <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_AMP_FIRST:     r_amp1  <= i_cfg_data[AMP_BITS-1:0];
                CFG_AMP_SECOND:    r_amp2  <= i_cfg_data[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the skid entry is free
    logic r_skid_v;
    logic w_en;
    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    // stage 1: elapsed time, before-start flag, span products
    logic                   r1_v, r2_v, r3_v;
    logic                   r1_before, r2_before;
    logic [TIME_BITS-1:0]   r1_elapsed, r2_elapsed;
    logic [PROD_BITS-1:0]   r1_base, r1_prod2;
    logic [TIME_BITS:0]     w_diff;
    logic [COUNT_BITS-1:0]  w_n1m1;

    assign w_diff = {1'b0, i_in.time_stamp} - {1'b0, r_start};
    // zero first count behaves as one pulse
    assign w_n1m1 = (r_cf == '0) ? '0 : r_cf - COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_before  <= w_diff[TIME_BITS];
            r1_elapsed <= w_diff[TIME_BITS-1:0];
            r1_base    <= PROD_BITS'(r_pf) * PROD_BITS'(w_n1m1);
            r1_prod2   <= PROD_BITS'(r_ps) * PROD_BITS'(r_cs);
        end
    end

    // stage 2: span ends and time since the last first-train pulse
    logic [CMP_BITS-1:0]  r2_span1, r2_span2;
    logic [TIME_BITS-1:0] r2_ediff;
    logic [CMP_BITS-1:0]  w_ediff;

    assign w_ediff = CMP_BITS'(r1_elapsed) - CMP_BITS'(r1_base);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_before  <= r1_before;
            r2_elapsed <= r1_elapsed;
            r2_span1   <= CMP_BITS'(r1_base) + CMP_BITS'(r_pw);
            r2_span2   <= CMP_BITS'(r1_base) + CMP_BITS'(r_pw) + CMP_BITS'(r1_prod2);
            r2_ediff   <= w_ediff[TIME_BITS-1:0];
        end
    end

    // stage 3: phase decision, pick dividend and divisor
    t_phase                 r3_phase;
    logic [TIME_BITS-1:0]   r3_dvd;
    logic [PERIOD_BITS-1:0] r3_dvs;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r2_before) begin
                r3_phase <= PH_BEFORE;
                r3_dvd   <= r2_elapsed;
                r3_dvs   <= r_pf;
            end else if (CMP_BITS'(r2_elapsed) <= r2_span1) begin
                r3_phase <= PH_FIRST;
                r3_dvd   <= r2_elapsed;
                r3_dvs   <= r_pf;
            end else if (CMP_BITS'(r2_elapsed) <= r2_span2) begin
                r3_phase <= PH_SECOND;
                r3_dvd   <= r2_ediff;
                r3_dvs   <= r_ps;
            end else begin
                r3_phase <= PH_DONE;
                r3_dvd   <= r2_elapsed;
                r3_dvs   <= r_pf;
            end
        end
    end

    // front-stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // remainder pipeline, one quotient bit per stage
    logic                   w_mv;
    logic [PERIOD_BITS-1:0] w_rem;
    t_mod_res               w_res;

    tppg_mod_pipe u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r3_v),
        .i_dividend (r3_dvd),
        .i_divisor  (r3_dvs),
        .i_limit    (r_pw),
        .i_phase    (r3_phase),
        .o_valid    (w_mv),
        .o_rem      (w_rem),
        .o_res      (w_res)
    );

    // result stage: pulse test and amplitude select
    logic                       r_ov;
    logic signed [AMP_BITS-1:0] r_oamp;
    logic                       r_oon;
    t_phase                     r_oph;
    logic                       w_le;
    logic                       w_on;

    // zero period compares the time itself
    assign w_le = w_res.pzero ? w_res.self_le : (w_rem <= r_pw);
    assign w_on = w_le && ((w_res.phase == PH_FIRST) || (w_res.phase == PH_SECOND));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oon <= w_on;
            r_oph <= w_res.phase;
            if (!w_on) begin
                r_oamp <= '0;
            end else if (w_res.phase == PH_SECOND) begin
                r_oamp <= r_amp2;
            end else begin
                r_oamp <= r_amp1;
            end
        end
    end

    // skid entry catches the result when the sink stalls
    logic signed [AMP_BITS-1:0] r_samp;
    logic                       r_son;
    t_phase                     r_sph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_mv;
            if (r_ov && !o_out.ready) begin
                r_skid_v <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_ov && !o_out.ready) begin
            r_samp <= r_oamp;
            r_son  <= r_oon;
            r_sph  <= r_oph;
        end
    end

    assign o_out.valid          = r_skid_v || r_ov;
    assign o_out.stim_amplitude = r_skid_v ? r_samp : r_oamp;
    assign o_out.pulse_on       = r_skid_v ? r_son : r_oon;
    assign o_out.train_phase    = r_skid_v ? r_sph : r_oph;

endmodule
